// File: hdl/rwams_pkg.sv
// ----------------------------------------------------------------------------
// rwams_pkg
// Shared types and constants for the rolling window average / max / slope
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwams_pkg;

  // Window depth; the average uses a shift, so keep it a power of two.
  localparam int WINDOW_DEPTH = 16;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W     = 16;
  localparam int TOTAL_W      = SAMPLE_W + ADDR_W;
  localparam int SLOPE_W      = SAMPLE_W + 1;
  localparam int SPAN_W       = 5;
  localparam int DIV_CNT_W    = $clog2(SAMPLE_W + 1);

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [SPAN_W-1:0]          span_t;

  // Sample memory access for one cycle.
  typedef struct packed {
    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
    addr_t   rd_addr;
  } ring_req_t;

  // Divider launch.
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] dividend;
    span_t               divisor;
  } div_req_t;

endpackage

// File: hdl/rwams_ring.sv
// ----------------------------------------------------------------------------
// rwams_ring
// Sample memory: one write and one read port, registered read data. Entries
// not written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwams_ring (
  input  logic                clk,
  input  logic                rst,
  input  rwams_pkg::ring_req_t req,
  output rwams_pkg::sample_t  rd_data
);
  import rwams_pkg::*;

  sample_t                 mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] valid;
  sample_t                 rd_q;
  logic                    rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_q <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_ok <= valid[req.rd_addr];
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// File: hdl/rwams_div.sv
// ----------------------------------------------------------------------------
// rwams_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwams_div (
  input  logic                             clk,
  input  logic                             rst,
  input  rwams_pkg::div_req_t              req,
  output logic                             done,
  output logic [rwams_pkg::SAMPLE_W-1:0]   quotient
);
  import rwams_pkg::*;

  logic [SAMPLE_W-1:0]  quo;
  span_t                rem;
  span_t                dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [SPAN_W:0]      shifted;
  logic [SPAN_W:0]      trial;

  assign shifted = {rem, quo[SAMPLE_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      // Keep the remainder when the trial goes negative.
      if (!trial[SPAN_W]) begin
        rem <= trial[SPAN_W-1:0];
        quo <= {quo[SAMPLE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[SPAN_W-1:0];
        quo <= {quo[SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SAMPLE_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/rolling_window_average_max_slope.sv
// ----------------------------------------------------------------------------
// rolling_window_average_max_slope
// Flow: one beat at a time; s_tready is high only in IDLE, so a new beat is
//   taken only after the previous result is loaded into the output register,
//   after the 16-entry memory scan (one read per cycle) and the bit-serial slope divide.
// Reset: rst clears the window to zero, write slot and total to zero, span 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rolling_window_average_max_slope (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] window_average, [31:16] window_maximum,
                                 // [48:32] ending_slope, [55:49] zero
  output logic        m_tuser,   // [0] slope_error
  // slope_span register write.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import rwams_pkg::*;

  // Sequencer: one item at a time.
  //   IDLE   : take a beat, read the slot about to be overwritten
  //   UPDATE : fold old/new sample into the total, write the new sample
  //   SCAN   : read every entry, track the maximum and catch the slope tap
  //   SLOPE  : form the difference and launch the divider
  //   DIVIDE : wait for the quotient
  //   EMIT   : load the output register once it is free
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UPDATE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_SLOPE  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  localparam logic [TOTAL_W-1:0] AVG_BIAS  = TOTAL_W'(WINDOW_DEPTH - 1);
  localparam logic [ADDR_W:0]    SCAN_LAST = (ADDR_W + 1)'(WINDOW_DEPTH);

  state_t state, state_next;

  span_t                     span;
  addr_t                     wpos;
  logic signed [TOTAL_W-1:0] total;
  sample_t                   sample_q;
  addr_t                     back_addr;
  sample_t                   back_val;
  sample_t                   max_val;
  logic [ADDR_W:0]           scan_cnt;
  logic                      slope_neg;
  logic                      slope_err;

  ring_req_t                 ring_req;
  sample_t                   ring_rd;
  div_req_t                  div_req;
  logic                      div_done;
  logic [SAMPLE_W-1:0]       div_quo;

  logic [SPAN_W:0]           back_calc;
  addr_t                     proc_addr;
  logic signed [SLOPE_W-1:0] diff;
  logic signed [SLOPE_W-1:0] diff_neg;
  logic [TOTAL_W-1:0]        biased;
  logic [SLOPE_W-1:0]        quo_ext;
  logic [SLOPE_W-1:0]        slope;
  logic                      out_free;

  rwams_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .req     (ring_req),
    .rd_data (ring_rd)
  );

  rwams_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Slope tap sits span slots behind the one being written (mod depth);
  // a span equal to the depth lands on the new sample itself.
  assign back_calc = (SPAN_W + 1)'(wpos) - (SPAN_W + 1)'(span);
  assign proc_addr = ADDR_W'(scan_cnt - (ADDR_W + 1)'(1));

  assign diff     = SLOPE_W'(sample_q) - SLOPE_W'(back_val);
  assign diff_neg = -diff;

  // Truncate toward zero: bias negative totals before the shift.
  assign biased  = total + (total[TOTAL_W-1] ? AVG_BIAS : '0);
  assign quo_ext = {1'b0, div_quo};
  assign slope   = slope_err ? '0 : (slope_neg ? (~quo_ext + SLOPE_W'(1)) : quo_ext);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Memory access: the read during IDLE fetches the entry about to be
  // replaced; the scan follows UPDATE, where the write lands, so it sees the new sample.
  always_comb begin
    ring_req.wr_en   = (state == ST_UPDATE);
    ring_req.wr_addr = wpos;
    ring_req.wr_data = sample_q;
    ring_req.rd_addr = (state == ST_SCAN) ? scan_cnt[ADDR_W-1:0] : wpos;
  end

  always_comb begin
    div_req.start    = (state == ST_SLOPE);
    div_req.dividend = diff[SLOPE_W-1] ? diff_neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
    div_req.divisor  = span;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt == SCAN_LAST) begin
          state_next = ST_SLOPE;
        end
      end
      ST_SLOPE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      span     <= SPAN_RESET;
      wpos     <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        span <= cfg_wdata;
      end
      if (state == ST_UPDATE) begin
        // Drop the overwritten sample from the total, add the new one.
        total <= total + TOTAL_W'(sample_q) - TOTAL_W'(ring_rd);
        wpos  <= wpos + ADDR_W'(1);
      end
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      sample_q <= s_tdata;
    end
    if (state == ST_UPDATE) begin
      back_addr <= back_calc[ADDR_W-1:0];
      scan_cnt  <= '0;
    end
    if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + (ADDR_W + 1)'(1);
      if (scan_cnt != '0) begin
        // Data now on the read port belongs to the previous address.
        if (scan_cnt == (ADDR_W + 1)'(1) || ring_rd > max_val) begin
          max_val <= ring_rd;
        end
        if (proc_addr == back_addr) begin
          back_val <= ring_rd;
        end
      end
    end
    if (state == ST_SLOPE) begin
      slope_neg <= diff[SLOPE_W-1];
      slope_err <= (span == '0) || (span > SPAN_W'(WINDOW_DEPTH));
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {7'b0, slope, max_val, biased[TOTAL_W-1:ADDR_W]};
      m_tuser <= slope_err;
    end
  end

endmodule

// File: verif/tb_rolling_window_average_max_slope.sv
// ----------------------------------------------------------------------------
// tb_rolling_window_average_max_slope
// Self-checking bench for the rolling window average / max / slope block.
// Every accepted sample is run through a local model of the window. The
// model predicts the average, maximum, slope and error flag, and each result
// beat is checked against the oldest prediction. Stimulus starts with a
// short set of edge values, then moves through spans in range, at the edges
// and out of range, with random idling on both streams and one long output
// stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rolling_window_average_max_slope;
  import rwams_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;    // wait after the last result before a span write or the end
  localparam int IDLE_PCT     = 12;
  localparam int HOLD_AT      = 100;   // result count that starts the long stall
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 100;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // One predicted result beat.
  typedef struct packed {
    sample_t             average;
    sample_t             maximum;
    logic signed [16:0]  slope;
    logic                slope_err;
  } window_stats_t;

  // Window model plus the queue of predicted results.
  class window_stats_scoreboard;
    sample_t       history[WINDOW_DEPTH];
    addr_t         next_slot;
    int            window_sum;
    span_t         span_cfg;
    window_stats_t stats_due[$];
    int            errors;

    function new();
      foreach (history[i]) history[i] = '0;
      next_slot  = '0;
      window_sum = 0;
      span_cfg   = SPAN_RESET;
      errors     = 0;
    endfunction

    function void set_span(span_t value);
      span_cfg = value;
    endfunction

    // Store the sample, then predict the beat it produces.
    function void take_sample(sample_t value);
      window_stats_t want;
      int            peak;
      int            back;
      window_sum = window_sum + int'(value) - int'(history[next_slot]);
      history[next_slot] = value;
      want.average = sample_t'(window_sum / WINDOW_DEPTH);
      peak = history[0];
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        if (int'(history[i]) > peak) peak = history[i];
      end
      want.maximum = sample_t'(peak);
      if (span_cfg == 0 || int'(span_cfg) > WINDOW_DEPTH) begin
        want.slope     = '0;
        want.slope_err = 1'b1;
      end else begin
        // At full depth this lands on the slot just written, so slope is 0.
        back = (int'(next_slot) + WINDOW_DEPTH - int'(span_cfg)) % WINDOW_DEPTH;
        want.slope     = 17'((int'(value) - int'(history[back])) / int'(span_cfg));
        want.slope_err = 1'b0;
      end
      next_slot = next_slot + 1'b1;
      stats_due.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task compare_stats(logic [55:0] data, logic err_flag);
      window_stats_t want;
      if (stats_due.size() == 0) begin
        report("result beat with no sample pending");
        return;
      end
      want = stats_due.pop_front();
      if (sample_t'(data[15:0]) !== want.average)
        report($sformatf("window_average got %0d want %0d",
                         $signed(data[15:0]), want.average));
      if (sample_t'(data[31:16]) !== want.maximum)
        report($sformatf("window_maximum got %0d want %0d",
                         $signed(data[31:16]), want.maximum));
      if (data[48:32] !== want.slope)
        report($sformatf("ending_slope got %0d want %0d",
                         $signed(data[48:32]), want.slope));
      if (err_flag !== want.slope_err)
        report($sformatf("slope_error got %b want %b", err_flag, want.slope_err));
      if (data[55:49] !== '0)
        report($sformatf("tdata padding got %h", data[55:49]));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  window_stats_scoreboard board = new();
  bit steady = 1'b0;   // set to run a stretch with no idling on either side
  int cycle_count = 0;

  rolling_window_average_max_slope DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: fail and end the run once the cycle counter reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one sample beat and hold it until the block takes it. Drop valid
  // for a random gap first unless a steady stretch is running.
  task automatic send_sample(sample_t value);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_sample(value);
  endtask

  // Write the span while the block is idle: drain all results, give the
  // pipeline its latency to settle, then pulse the write enable.
  task automatic write_span(span_t value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_span(value);
  endtask

  // Random samples: full-range noise, constant runs of edge values (some
  // long enough to fill the window), ramps, and values hovering near zero.
  task automatic send_random(int count);
    int      sent;
    int      len;
    int      pick;
    sample_t value;
    sample_t stride;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(9);
      len  = $urandom_range(8, 24);
      if (pick < 4) begin
        send_sample(sample_t'($urandom));
        sent++;
      end else if (pick < 6) begin
        case ($urandom_range(3))
          0:       value = SAMPLE_MAX;
          1:       value = SAMPLE_MIN;
          2:       value = '0;
          default: value = -16'sd1;
        endcase
        repeat (len) send_sample(value);
        sent += len;
      end else if (pick < 8) begin
        value  = sample_t'($urandom);
        stride = sample_t'($urandom_range(0, 4000)) - 16'sd2000;
        repeat (len) begin
          send_sample(value);
          value = value + stride;
        end
        sent += len;
      end else begin
        send_sample(sample_t'($urandom_range(0, 64)) - 16'sd32);
        sent++;
      end
    end
  endtask

  // Result side: check every beat, idle at random, and once hold off for a
  // long stretch so the block backs up into its input.
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready && !rst) begin
        board.compare_stats(m_tdata, m_tuser);
        seen++;
        if (seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    sample_t edge_values[$];
    span_t   spans[$];
    edge_values = '{16'sd0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                    -16'sd1, 16'sd1, 16'sh5555, 16'shAAAA};
    spans       = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd2, 5'd8, 5'd15};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Span 1 out of reset: largest positive and negative slopes, sign
    // patterns, then a full window at the top value.
    foreach (edge_values[i]) send_sample(edge_values[i]);
    repeat (WINDOW_DEPTH) send_sample(SAMPLE_MAX);
    send_random(PHASE_ITEMS);

    // Walk through the spans; run the full-depth span with no idling at all.
    foreach (spans[i]) begin
      write_span(spans[i]);
      steady = (spans[i] == span_t'(WINDOW_DEPTH));
      send_random(PHASE_ITEMS);
    end
    steady = 1'b0;
    write_span(span_t'($urandom_range(0, 31)));
    send_random(PHASE_ITEMS);
    write_span(5'd3);
    send_random(PHASE_ITEMS);

    // Drain, then wait out the latency for any stray beat.
    s_tvalid <= 1'b0;
    while (board.stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
